@@ sv/ktci_pkg.sv @@
`default_nettype none

package ktci_pkg;

    // table size default
    localparam int TABLE_DEPTH_DEF = 10;

    // entry geometry
    localparam int KEY_BYTES = 29;
    localparam int TAG_BYTES = 19;
    localparam int KEY_W     = KEY_BYTES * 8;
    localparam int TAG_W     = TAG_BYTES * 8;
    localparam int AMT_W     = 31;

    // command codes
    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_REMOVE = 2'd1;
    localparam logic [1:0] CMD_SEARCH = 2'd2;
    localparam logic [1:0] CMD_LIST   = 2'd3;

    // result status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_FULL      = 3'd1;
    localparam logic [2:0] ST_DUPLICATE = 3'd2;
    localparam logic [2:0] ST_BAD_QTY   = 3'd3;
    localparam logic [2:0] ST_EMPTY     = 3'd4;
    localparam logic [2:0] ST_NOT_FOUND = 3'd5;

    // slot source select
    localparam logic [1:0] SL_ZERO   = 2'd0;
    localparam logic [1:0] SL_RDADDR = 2'd1;
    localparam logic [1:0] SL_COUNT  = 2'd2;
    localparam logic [1:0] SL_HIT    = 2'd3;

    // one stored entry
    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [TAG_W-1:0] tag;
        logic [AMT_W-1:0] amount;
    } t_entry;

    // controller to datapath commands
    typedef struct packed {
        logic       load;
        logic       rd_en;
        logic       hit_load;
        logic       ins_wr;
        logic       shift_wr;
        logic       emit;
        logic [2:0] status;
        logic [1:0] slot_sel;
        logic       data_en;
        logic       last;
        logic       cnt_inc;
        logic       cnt_dec;
    } t_dp_cmd;

    // datapath to controller status
    typedef struct packed {
        logic [1:0] command;
        logic       cnt_zero;
        logic       full;
        logic       amt_bad;
        logic       idx_lt_cnt;
        logic       rd_vld;
        logic       match;
        logic       rd_last;
    } t_dp_stat;

endpackage

`default_nettype wire

@@ sv/ktci_dp.sv @@
`default_nettype none

module ktci_dp import ktci_pkg::*; #(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_dp_cmd            i_cmd,
    output t_dp_stat           o_stat,
    input  logic [1:0]         i_command,
    input  logic [63:0]        i_key_w0,
    input  logic [63:0]        i_key_w1,
    input  logic [63:0]        i_key_w2,
    input  logic [39:0]        i_key_w3,
    input  logic [63:0]        i_tag_w0,
    input  logic [63:0]        i_tag_w1,
    input  logic [23:0]        i_tag_w2,
    input  logic signed [31:0] i_amount,
    output logic               o_valid,
    output logic [2:0]         o_status,
    output logic [3:0]         o_slot,
    output logic [63:0]        o_out_key_w0,
    output logic [63:0]        o_out_key_w1,
    output logic [63:0]        o_out_key_w2,
    output logic [39:0]        o_out_key_w3,
    output logic [63:0]        o_out_tag_w0,
    output logic [63:0]        o_out_tag_w1,
    output logic [23:0]        o_out_tag_w2,
    output logic [30:0]        o_out_amount,
    output logic [3:0]         o_live_count,
    output logic               o_last
);

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);
    localparam logic [CNT_W-1:0] CNT_ONE   = CNT_W'(1);
    localparam logic [IDX_W-1:0] IDX_ONE   = IDX_W'(1);
    localparam logic [7:0] CH_UPPER_A  = 8'h41;
    localparam logic [7:0] CH_UPPER_Z  = 8'h5A;
    localparam logic [7:0] CASE_OFFSET = 8'd32;

    // clear every byte after the first zero byte
    function automatic logic [KEY_W-1:0] terminate_str(input logic [KEY_W-1:0] v);
        logic             ended;
        logic [KEY_W-1:0] r;
        ended = 1'b0;
        r     = v;
        for (int b = 0; b < KEY_BYTES; b++) begin
            if (ended) begin
                r[b*8 +: 8] = 8'h00;
            end else if (v[b*8 +: 8] == 8'h00) begin
                ended = 1'b1;
            end
        end
        return r;
    endfunction

    // lower A-Z only
    function automatic logic [7:0] fold_byte(input logic [7:0] c);
        return (c >= CH_UPPER_A && c <= CH_UPPER_Z) ? c + CASE_OFFSET : c;
    endfunction

    function automatic logic [KEY_W-1:0] fold_key(input logic [KEY_W-1:0] v);
        logic [KEY_W-1:0] r;
        r = '0;
        for (int b = 0; b < KEY_BYTES; b++) begin
            r[b*8 +: 8] = fold_byte(v[b*8 +: 8]);
        end
        return r;
    endfunction

    logic [1:0]       r_cmd;
    logic [KEY_W-1:0] r_key;
    logic [KEY_W-1:0] r_key_fold;
    logic [TAG_W-1:0] r_tag;
    logic [AMT_W-1:0] r_amount;
    logic             r_amt_bad;
    logic [KEY_W-1:0] key_term;
    logic [KEY_W-1:0] tag_term;

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic [CNT_W-1:0] r_idx;
    logic [IDX_W-1:0] rd_addr;
    logic [IDX_W-1:0] r_rd_addr;
    logic [IDX_W-1:0] r_hit;
    logic [IDX_W-1:0] wr_addr;
    logic             r_rd_vld;
    logic             wr_en;
    t_entry           wr_data;
    t_entry           r_rd_data;
    t_entry           r_mem [TABLE_DEPTH];

    logic [2:0]       r_status;
    logic [3:0]       r_slot;
    logic [3:0]       r_live;
    logic             r_last;
    logic             r_valid;
    t_entry           r_out_entry;
    logic [3:0]       slot_val;
    logic [CNT_W+3:0] slot_wide;
    logic [CNT_W+3:0] live_wide;

    // input string cleanup
    assign key_term = terminate_str({i_key_w3, i_key_w2, i_key_w1, i_key_w0});
    assign tag_term = terminate_str(KEY_W'({i_tag_w2, i_tag_w1, i_tag_w0}));

    // transaction capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd      <= i_command;
            r_key      <= key_term;
            r_key_fold <= fold_key(key_term);
            r_tag      <= tag_term[TAG_W-1:0];
            r_amount   <= i_amount[AMT_W-1:0];
            r_amt_bad  <= i_amount[31] || (i_amount == 32'sd0);
        end
    end

    // walk index and hit slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (i_cmd.load) begin
            r_idx <= '0;
        end else if (i_cmd.hit_load) begin
            r_idx <= CNT_W'(r_rd_addr) + CNT_ONE;
        end else if (i_cmd.rd_en) begin
            r_idx <= r_idx + CNT_ONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.hit_load) begin
            r_hit <= r_rd_addr;
        end
    end

    // entry count
    always_comb begin
        n_count = r_count;
        if (i_cmd.cnt_inc) begin
            n_count = r_count + CNT_ONE;
        end else if (i_cmd.cnt_dec) begin
            n_count = r_count - CNT_ONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    // table memory, one write and one registered read per cycle
    assign rd_addr = r_idx[IDX_W-1:0];
    assign wr_en   = i_cmd.ins_wr || (i_cmd.shift_wr && r_rd_vld);
    assign wr_addr = i_cmd.ins_wr ? r_count[IDX_W-1:0] : r_rd_addr - IDX_ONE;
    assign wr_data = i_cmd.ins_wr ? {r_key, r_tag, r_amount} : r_rd_data;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= r_mem[rd_addr];
            r_rd_addr <= rd_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= i_cmd.rd_en;
        end
    end

    // status to controller
    assign o_stat.command    = r_cmd;
    assign o_stat.cnt_zero   = (r_count == '0);
    assign o_stat.full       = (r_count >= DEPTH_CNT);
    assign o_stat.amt_bad    = r_amt_bad;
    assign o_stat.idx_lt_cnt = (r_idx < r_count);
    assign o_stat.rd_vld     = r_rd_vld;
    assign o_stat.match      = r_rd_vld && (fold_key(r_rd_data.key) == r_key_fold);
    assign o_stat.rd_last    = ((CNT_W'(r_rd_addr) + CNT_ONE) == r_count);

    // slot source
    always_comb begin
        unique case (i_cmd.slot_sel)
            SL_RDADDR: slot_wide = (CNT_W+4)'(r_rd_addr);
            SL_COUNT:  slot_wide = (CNT_W+4)'(r_count);
            SL_HIT:    slot_wide = (CNT_W+4)'(r_hit);
            default:   slot_wide = '0;
        endcase
        slot_val  = slot_wide[3:0];
        live_wide = (CNT_W+4)'(n_count);
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_status    <= i_cmd.status;
            r_slot      <= slot_val;
            r_live      <= live_wide[3:0];
            r_last      <= i_cmd.last;
            r_out_entry <= i_cmd.data_en ? r_rd_data : '0;
        end
    end

    assign o_valid      = r_valid;
    assign o_status     = r_status;
    assign o_slot       = r_slot;
    assign o_live_count = r_live;
    assign o_last       = r_last;
    assign o_out_key_w0 = r_out_entry.key[63:0];
    assign o_out_key_w1 = r_out_entry.key[127:64];
    assign o_out_key_w2 = r_out_entry.key[191:128];
    assign o_out_key_w3 = r_out_entry.key[231:192];
    assign o_out_tag_w0 = r_out_entry.tag[63:0];
    assign o_out_tag_w1 = r_out_entry.tag[127:64];
    assign o_out_tag_w2 = r_out_entry.tag[151:128];
    assign o_out_amount = r_out_entry.amount;

    // count stays within the table
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= DEPTH_CNT)
        else $error("entry count above table depth");

    // insert writes only into a free slot
    a_insert_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.ins_wr |-> (r_count < DEPTH_CNT))
        else $error("insert write on a full table");

    // compaction never moves the first entry down
    a_shift_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.shift_wr && r_rd_vld) |-> (r_rd_addr != '0))
        else $error("compaction write below slot zero");

    // reads stay below the live count
    a_read_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.rd_en |-> (r_idx < r_count))
        else $error("table read beyond live entries");

endmodule

`default_nettype wire

@@ sv/ktci_ctrl.sv @@
`default_nettype none

module ktci_ctrl import ktci_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     start,
    output logic     busy,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_DISPATCH = 3'd1;
    localparam logic [2:0] S_SCAN     = 3'd2;
    localparam logic [2:0] S_SHIFT    = 3'd3;
    localparam logic [2:0] S_LIST     = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;
    t_dp_cmd    c;

    // sequencing
    always_comb begin
        n_state    = r_state;
        c          = '0;
        c.last     = 1'b1;
        c.status   = ST_OK;
        c.slot_sel = SL_ZERO;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    c.load  = 1'b1;
                    n_state = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                unique case (i_stat.command)
                    CMD_INSERT: begin
                        if (i_stat.full) begin
                            c.emit   = 1'b1;
                            c.status = ST_FULL;
                            n_state  = S_IDLE;
                        end else if (i_stat.cnt_zero) begin
                            // empty table, nothing to match
                            c.emit  = 1'b1;
                            n_state = S_IDLE;
                            if (i_stat.amt_bad) begin
                                c.status = ST_BAD_QTY;
                            end else begin
                                c.ins_wr   = 1'b1;
                                c.slot_sel = SL_COUNT;
                                c.cnt_inc  = 1'b1;
                            end
                        end else begin
                            n_state = S_SCAN;
                        end
                    end
                    CMD_LIST: begin
                        if (i_stat.cnt_zero) begin
                            c.emit   = 1'b1;
                            c.status = ST_EMPTY;
                            n_state  = S_IDLE;
                        end else begin
                            n_state = S_LIST;
                        end
                    end
                    default: begin
                        if (i_stat.cnt_zero) begin
                            c.emit   = 1'b1;
                            c.status = ST_EMPTY;
                            n_state  = S_IDLE;
                        end else begin
                            n_state = S_SCAN;
                        end
                    end
                endcase
            end
            S_SCAN: begin
                if (i_stat.match) begin
                    unique case (i_stat.command)
                        CMD_INSERT: begin
                            c.emit     = 1'b1;
                            c.status   = ST_DUPLICATE;
                            c.slot_sel = SL_RDADDR;
                            n_state    = S_IDLE;
                        end
                        CMD_REMOVE: begin
                            c.hit_load = 1'b1;
                            n_state    = S_SHIFT;
                        end
                        default: begin
                            c.emit     = 1'b1;
                            c.slot_sel = SL_RDADDR;
                            c.data_en  = 1'b1;
                            n_state    = S_IDLE;
                        end
                    endcase
                end else if (!i_stat.idx_lt_cnt && !i_stat.rd_vld) begin
                    // walked every entry with no match
                    c.emit  = 1'b1;
                    n_state = S_IDLE;
                    if (i_stat.command != CMD_INSERT) begin
                        c.status = ST_NOT_FOUND;
                    end else if (i_stat.amt_bad) begin
                        c.status = ST_BAD_QTY;
                    end else begin
                        c.ins_wr   = 1'b1;
                        c.slot_sel = SL_COUNT;
                        c.cnt_inc  = 1'b1;
                    end
                end else begin
                    c.rd_en = i_stat.idx_lt_cnt;
                end
            end
            S_SHIFT: begin
                c.shift_wr = 1'b1;
                if (!i_stat.idx_lt_cnt && !i_stat.rd_vld) begin
                    c.emit     = 1'b1;
                    c.slot_sel = SL_HIT;
                    c.cnt_dec  = 1'b1;
                    n_state    = S_IDLE;
                end else begin
                    c.rd_en = i_stat.idx_lt_cnt;
                end
            end
            S_LIST: begin
                c.rd_en = i_stat.idx_lt_cnt;
                if (i_stat.rd_vld) begin
                    c.emit     = 1'b1;
                    c.slot_sel = SL_RDADDR;
                    c.data_en  = 1'b1;
                    c.last     = i_stat.rd_last;
                    if (i_stat.rd_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy  = (r_state != S_IDLE);
    assign o_cmd = c;

    // the final result of a transaction frees the block
    a_last_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.emit && o_cmd.last) |=> !busy)
        else $error("block still busy after final result");

endmodule

`default_nettype wire

@@ sv/keyed_table_case_insensitive_top.sv @@
`default_nettype none

// channel   direction  handshake                 fields
// command   in         start & !busy accepts     i_command, i_key_w0..3, i_tag_w0..2, i_amount
// result    out        o_valid for one cycle     o_status, o_slot, o_out_key_w0..3,
//                                                o_out_tag_w0..2, o_out_amount,
//                                                o_live_count, o_last
//
// insert, remove and search walk the table one entry per cycle through its
// registered read port, and remove then compacts the entries above the hit;
// list gives one result per cycle.
// i_rst_n (synchronous) empties the table; stored entries need no clearing.
// results cannot be held off; busy stays high until the last one is issued.

module keyed_table_case_insensitive_top import ktci_pkg::*; #(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         i_command,
    input  logic [63:0]        i_key_w0,
    input  logic [63:0]        i_key_w1,
    input  logic [63:0]        i_key_w2,
    input  logic [39:0]        i_key_w3,
    input  logic [63:0]        i_tag_w0,
    input  logic [63:0]        i_tag_w1,
    input  logic [23:0]        i_tag_w2,
    input  logic signed [31:0] i_amount,
    output logic               o_valid,
    output logic [2:0]         o_status,
    output logic [3:0]         o_slot,
    output logic [63:0]        o_out_key_w0,
    output logic [63:0]        o_out_key_w1,
    output logic [63:0]        o_out_key_w2,
    output logic [39:0]        o_out_key_w3,
    output logic [63:0]        o_out_tag_w0,
    output logic [63:0]        o_out_tag_w1,
    output logic [23:0]        o_out_tag_w2,
    output logic [30:0]        o_out_amount,
    output logic [3:0]         o_live_count,
    output logic               o_last
);

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    // sequencer
    ktci_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_stat  (dp_stat),
        .o_cmd   (dp_cmd)
    );

    // table storage, matching and result register
    ktci_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (dp_cmd),
        .o_stat       (dp_stat),
        .i_command    (i_command),
        .i_key_w0     (i_key_w0),
        .i_key_w1     (i_key_w1),
        .i_key_w2     (i_key_w2),
        .i_key_w3     (i_key_w3),
        .i_tag_w0     (i_tag_w0),
        .i_tag_w1     (i_tag_w1),
        .i_tag_w2     (i_tag_w2),
        .i_amount     (i_amount),
        .o_valid      (o_valid),
        .o_status     (o_status),
        .o_slot       (o_slot),
        .o_out_key_w0 (o_out_key_w0),
        .o_out_key_w1 (o_out_key_w1),
        .o_out_key_w2 (o_out_key_w2),
        .o_out_key_w3 (o_out_key_w3),
        .o_out_tag_w0 (o_out_tag_w0),
        .o_out_tag_w1 (o_out_tag_w1),
        .o_out_tag_w2 (o_out_tag_w2),
        .o_out_amount (o_out_amount),
        .o_live_count (o_live_count),
        .o_last       (o_last)
    );

endmodule

`default_nettype wire

@@ bench/tb.sv @@
import ktci_pkg::*;

// one result as seen on the output ports
typedef struct {
    logic [2:0]       status;
    logic [3:0]       slot;
    logic [KEY_W-1:0] key;
    logic [TAG_W-1:0] tag;
    logic [AMT_W-1:0] amount;
    logic [3:0]       live_count;
    logic             last;
} t_table_result;

// table predictor plus queue of awaited results
class table_scoreboard;
    logic [KEY_W-1:0] names [TABLE_DEPTH_DEF];
    logic [TAG_W-1:0] tags [TABLE_DEPTH_DEF];
    logic [AMT_W-1:0] amounts [TABLE_DEPTH_DEF];
    int               count;
    t_table_result    awaited_results [$];
    int               mismatch_count;

    function new();
        count = 0;
        mismatch_count = 0;
    endfunction

    // zero every byte after the first zero byte and every byte from nbytes on
    function logic [KEY_W-1:0] clip_text(logic [KEY_W-1:0] v, int nbytes);
        bit ended;
        ended = 1'b0;
        for (int i = 0; i < KEY_BYTES; i++) begin
            if (ended || i >= nbytes) begin
                v[8*i +: 8] = 8'h00;
            end else if (v[8*i +: 8] == 8'h00) begin
                ended = 1'b1;
            end
        end
        return v;
    endfunction

    // lower only the bytes 'A'..'Z'
    function logic [7:0] fold(logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
    endfunction

    // linear search over the live entries
    function int find_name(logic [KEY_W-1:0] key);
        bit same;
        for (int i = 0; i < count; i++) begin
            same = 1'b1;
            for (int j = 0; j < KEY_BYTES; j++) begin
                if (fold(names[i][8*j +: 8]) != fold(key[8*j +: 8]))
                    same = 1'b0;
            end
            if (same)
                return i;
        end
        return -1;
    endfunction

    // queue one awaited result; idx < 0 means no entry data
    function void await_result(logic [2:0] status, int slot, int idx, bit last);
        t_table_result r;
        r.status = status;
        r.slot = slot[3:0];
        r.key = '0;
        r.tag = '0;
        r.amount = '0;
        if (idx >= 0) begin
            r.key = names[idx];
            r.tag = tags[idx];
            r.amount = amounts[idx];
        end
        r.live_count = count[3:0];
        r.last = last;
        awaited_results.push_back(r);
    endfunction

    // accepted transaction: update the table and predict its results
    function void note_command(logic [1:0] cmd, logic [KEY_W-1:0] key_in,
                               logic [TAG_W-1:0] tag_in, logic signed [31:0] amt);
        logic [KEY_W-1:0] key;
        logic [KEY_W-1:0] tag_clip;
        int hit;
        key = clip_text(key_in, KEY_BYTES);
        case (cmd)
            CMD_INSERT: begin
                if (count >= TABLE_DEPTH_DEF) begin
                    await_result(ST_FULL, 0, -1, 1'b1);
                end else begin
                    hit = find_name(key);
                    if (hit >= 0) begin
                        await_result(ST_DUPLICATE, hit, -1, 1'b1);
                    end else if (amt <= 0) begin
                        await_result(ST_BAD_QTY, 0, -1, 1'b1);
                    end else begin
                        tag_clip = clip_text({{(KEY_W-TAG_W){1'b0}}, tag_in}, TAG_BYTES);
                        names[count] = key;
                        tags[count] = tag_clip[TAG_W-1:0];
                        amounts[count] = amt[AMT_W-1:0];
                        count++;
                        await_result(ST_OK, count - 1, -1, 1'b1);
                    end
                end
            end
            CMD_LIST: begin
                if (count == 0) begin
                    await_result(ST_EMPTY, 0, -1, 1'b1);
                end else begin
                    for (int i = 0; i < count; i++)
                        await_result(ST_OK, i, i, i == count - 1);
                end
            end
            default: begin
                if (count == 0) begin
                    await_result(ST_EMPTY, 0, -1, 1'b1);
                end else begin
                    hit = find_name(key);
                    if (hit < 0) begin
                        await_result(ST_NOT_FOUND, 0, -1, 1'b1);
                    end else if (cmd == CMD_SEARCH) begin
                        await_result(ST_OK, hit, hit, 1'b1);
                    end else begin
                        // compact the entries above the removed one
                        for (int i = hit; i < count - 1; i++) begin
                            names[i] = names[i+1];
                            tags[i] = tags[i+1];
                            amounts[i] = amounts[i+1];
                        end
                        count--;
                        await_result(ST_OK, hit, -1, 1'b1);
                    end
                end
            end
        endcase
    endfunction

    function void compare(string field, logic [63:0] want, logic [63:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
            mismatch_count++;
        end
    endfunction

    // match one result against the oldest awaited one
    function void check_result(t_table_result got);
        t_table_result want;
        if (awaited_results.size() == 0) begin
            $error("result with no transaction pending: status %0d slot %0d",
                   got.status, got.slot);
            mismatch_count++;
            return;
        end
        want = awaited_results.pop_front();
        compare("status", 64'(want.status), 64'(got.status));
        compare("slot", 64'(want.slot), 64'(got.slot));
        compare("out_key_w0", want.key[63:0], got.key[63:0]);
        compare("out_key_w1", want.key[127:64], got.key[127:64]);
        compare("out_key_w2", want.key[191:128], got.key[191:128]);
        compare("out_key_w3", 64'(want.key[231:192]), 64'(got.key[231:192]));
        compare("out_tag_w0", want.tag[63:0], got.tag[63:0]);
        compare("out_tag_w1", want.tag[127:64], got.tag[127:64]);
        compare("out_tag_w2", 64'(want.tag[151:128]), 64'(got.tag[151:128]));
        compare("out_amount", 64'(want.amount), 64'(got.amount));
        compare("live_count", 64'(want.live_count), 64'(got.live_count));
        compare("last", 64'(want.last), 64'(got.last));
    endfunction

    function int pending();
        return awaited_results.size();
    endfunction
endclass

module tb;
    localparam int STALL_LIMIT = 2000;
    localparam int PHASE_ITEMS = 115;
    localparam int POOL_SIZE   = 14;
    localparam int TAIL_CYCLES = 40;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic [1:0]         i_command;
    logic [63:0]        i_key_w0;
    logic [63:0]        i_key_w1;
    logic [63:0]        i_key_w2;
    logic [39:0]        i_key_w3;
    logic [63:0]        i_tag_w0;
    logic [63:0]        i_tag_w1;
    logic [23:0]        i_tag_w2;
    logic signed [31:0] i_amount;
    logic               o_valid;
    logic [2:0]         o_status;
    logic [3:0]         o_slot;
    logic [63:0]        o_out_key_w0;
    logic [63:0]        o_out_key_w1;
    logic [63:0]        o_out_key_w2;
    logic [39:0]        o_out_key_w3;
    logic [63:0]        o_out_tag_w0;
    logic [63:0]        o_out_tag_w1;
    logic [23:0]        o_out_tag_w2;
    logic [30:0]        o_out_amount;
    logic [3:0]         o_live_count;
    logic               o_last;

    table_scoreboard  sb;
    logic [KEY_W-1:0] name_pool [POOL_SIZE];
    t_table_result    seen;
    int               stall_cycles;

    keyed_table_case_insensitive_top dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_command    (i_command),
        .i_key_w0     (i_key_w0),
        .i_key_w1     (i_key_w1),
        .i_key_w2     (i_key_w2),
        .i_key_w3     (i_key_w3),
        .i_tag_w0     (i_tag_w0),
        .i_tag_w1     (i_tag_w1),
        .i_tag_w2     (i_tag_w2),
        .i_amount     (i_amount),
        .o_valid      (o_valid),
        .o_status     (o_status),
        .o_slot       (o_slot),
        .o_out_key_w0 (o_out_key_w0),
        .o_out_key_w1 (o_out_key_w1),
        .o_out_key_w2 (o_out_key_w2),
        .o_out_key_w3 (o_out_key_w3),
        .o_out_tag_w0 (o_out_tag_w0),
        .o_out_tag_w1 (o_out_tag_w1),
        .o_out_tag_w2 (o_out_tag_w2),
        .o_out_amount (o_out_amount),
        .o_live_count (o_live_count),
        .o_last       (o_last)
    );

    // clock
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // text helpers, byte 0 in the low bits
    function automatic logic [KEY_W-1:0] str_text(string s);
        logic [KEY_W-1:0] v;
        v = '0;
        for (int i = 0; i < s.len() && i < KEY_BYTES; i++)
            v[8*i +: 8] = s[i];
        return v;
    endfunction

    function automatic logic [7:0] random_char();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return 8'h41 + 8'($urandom_range(0, 25));
            4, 5, 6:    return 8'h61 + 8'($urandom_range(0, 25));
            7:          return 8'h30 + 8'($urandom_range(0, 9));
            // neighbors of the letter ranges
            8: begin
                case ($urandom_range(0, 3))
                    0:       return 8'h40;
                    1:       return 8'h5B;
                    2:       return 8'h60;
                    default: return 8'h7B;
                endcase
            end
            default:    return 8'($urandom_range(1, 255));
        endcase
    endfunction

    function automatic logic [KEY_W-1:0] fresh_text(int max_len);
        logic [KEY_W-1:0] v;
        int len;
        len = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, max_len);
        v = '0;
        for (int i = 0; i < len; i++)
            v[8*i +: 8] = random_char();
        return v;
    endfunction

    // junk after the terminator, which the block must ignore
    function automatic logic [KEY_W-1:0] add_garbage(logic [KEY_W-1:0] v, int nbytes);
        int z;
        z = -1;
        for (int i = 0; i < nbytes && z < 0; i++)
            if (v[8*i +: 8] == 8'h00)
                z = i;
        if (z >= 0)
            for (int j = z + 1; j < nbytes; j++)
                v[8*j +: 8] = 8'($urandom_range(0, 255));
        return v;
    endfunction

    function automatic logic [KEY_W-1:0] vary_case(logic [KEY_W-1:0] v);
        logic [7:0] c;
        for (int i = 0; i < KEY_BYTES; i++) begin
            c = v[8*i +: 8];
            if (c == 8'h00)
                break;
            if (((c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A))
                && $urandom_range(0, 1))
                v[8*i +: 8] = c ^ 8'h20;
        end
        return v;
    endfunction

    function automatic logic [KEY_W-1:0] random_bits();
        logic [255:0] w;
        for (int j = 0; j < 8; j++)
            w[32*j +: 32] = $urandom;
        return w[KEY_W-1:0];
    endfunction

    // mostly names from the pool so that hits and duplicates are common
    function automatic logic [KEY_W-1:0] pick_name();
        logic [KEY_W-1:0] v;
        case ($urandom_range(0, 9))
            7, 8:    v = fresh_text(KEY_BYTES);
            9:       return random_bits();
            default: v = vary_case(name_pool[$urandom_range(0, POOL_SIZE - 1)]);
        endcase
        if ($urandom_range(0, 2) == 0)
            v = add_garbage(v, KEY_BYTES);
        return v;
    endfunction

    function automatic logic [KEY_W-1:0] pick_tag();
        if ($urandom_range(0, 1))
            return add_garbage(fresh_text(TAG_BYTES), TAG_BYTES);
        return random_bits();
    endfunction

    function automatic logic signed [31:0] pick_amount();
        case ($urandom_range(0, 9))
            7:       return 32'sd0;
            8:       return $urandom | 32'h8000_0000;
            9:       return $urandom;
            default: return $urandom_range(1, 32'h7FFF_FFFF);
        endcase
    endfunction

    // lean toward remove when the table is nearly full
    function automatic logic [1:0] pick_command();
        int r;
        int ins_cut;
        r = $urandom_range(0, 99);
        ins_cut = (sb.count >= 9) ? 25 : 45;
        if (r < ins_cut)
            return CMD_INSERT;
        if (r < 60)
            return CMD_REMOVE;
        if (r < 85)
            return CMD_SEARCH;
        return CMD_LIST;
    endfunction

    // present one transaction once the block is free; idle_pct percent of the
    // free cycles are left idle first
    task automatic issue_command(input logic [1:0] cmd, input logic [KEY_W-1:0] key,
                                 input logic [KEY_W-1:0] tag,
                                 input logic signed [31:0] amt,
                                 input int idle_pct = 0);
        @(negedge i_clk);
        while (busy || ($urandom_range(0, 99) < idle_pct)) begin
            start <= 1'b0;
            i_command <= 2'($urandom);
            @(negedge i_clk);
        end
        start <= 1'b1;
        i_command <= cmd;
        i_key_w0 <= key[63:0];
        i_key_w1 <= key[127:64];
        i_key_w2 <= key[191:128];
        i_key_w3 <= key[231:192];
        i_tag_w0 <= tag[63:0];
        i_tag_w1 <= tag[127:64];
        i_tag_w2 <= tag[151:128];
        i_amount <= amt;
        @(posedge i_clk);
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        start <= 1'b0;
        while (sb.pending() != 0)
            @(posedge i_clk);
    endtask

    // result check, transaction capture and stall watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid) begin
                seen.status = o_status;
                seen.slot = o_slot;
                seen.key = {o_out_key_w3, o_out_key_w2, o_out_key_w1, o_out_key_w0};
                seen.tag = {o_out_tag_w2, o_out_tag_w1, o_out_tag_w0};
                seen.amount = o_out_amount;
                seen.live_count = o_live_count;
                seen.last = o_last;
                sb.check_result(seen);
            end
            if (start && !busy)
                sb.note_command(i_command, {i_key_w3, i_key_w2, i_key_w1, i_key_w0},
                                {i_tag_w2, i_tag_w1, i_tag_w0}, i_amount);
            if (o_valid || (start && !busy))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $error("no transaction for %0d cycles", STALL_LIMIT);
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    initial begin
        logic [KEY_W-1:0] long_name;
        string            fill_names [5];
        int               idle_pct;

        sb = new();
        stall_cycles = 0;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_command = CMD_INSERT;
        i_key_w0 = '0;
        i_key_w1 = '0;
        i_key_w2 = '0;
        i_key_w3 = '0;
        i_tag_w0 = '0;
        i_tag_w1 = '0;
        i_tag_w2 = '0;
        i_amount = '0;
        fill_names = '{"Delta", "eps_9", "Zz", "Omega.long_name~x", "kappa"};
        for (int i = 0; i < POOL_SIZE; i++)
            name_pool[i] = fresh_text(KEY_BYTES);

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // empty table on list, search and remove
        issue_command(CMD_LIST, '0, '0, 0);
        issue_command(CMD_SEARCH, str_text("Alpha"), '0, 0);
        issue_command(CMD_REMOVE, str_text("Alpha"), '0, 0);

        // insert, duplicate in other case, bad quantities
        issue_command(CMD_INSERT, str_text("Alpha"), str_text("fruit"), 32'sd1);
        issue_command(CMD_INSERT, str_text("ALPHA"), str_text("other"), 32'sd5);
        issue_command(CMD_INSERT, str_text("beta"), str_text("x"), 32'sd0);
        issue_command(CMD_INSERT, str_text("beta"), str_text("x"), 32'sh8000_0000);

        // full-length name with no terminator, largest quantity
        long_name = str_text("AbCdEfGhIjKlMnOpQrStUvWxYz@[Z");
        issue_command(CMD_INSERT, long_name, {KEY_W{1'b1}}, 32'sh7FFF_FFFF);

        // junk after the terminator in name and tag
        issue_command(CMD_INSERT, add_garbage(str_text("gamma"), KEY_BYTES),
                      add_garbage(str_text("widget"), TAG_BYTES), 32'sd3);
        issue_command(CMD_SEARCH, add_garbage(str_text("GaMmA"), KEY_BYTES), '0, 0);

        // characters next to the letter ranges are not folded
        issue_command(CMD_INSERT, str_text("@["), str_text("edge"), 32'sd9);
        issue_command(CMD_SEARCH, str_text("`{"), '0, 0);

        // empty name is a valid key
        issue_command(CMD_INSERT, '0, str_text("none"), 32'sd2);
        wait_drained();

        // fill up, then full wins over duplicate and bad quantity
        foreach (fill_names[i])
            issue_command(CMD_INSERT, str_text(fill_names[i]), str_text(fill_names[i]),
                          pick_amount() & 32'h7FFF_FFFF | 32'h1);
        issue_command(CMD_INSERT, str_text("Zeta"), str_text("t"), 32'sd4);
        issue_command(CMD_INSERT, str_text("alpha"), str_text("t"), 32'sd0);
        issue_command(CMD_LIST, '0, '0, 0);
        issue_command(CMD_SEARCH, add_garbage('0, KEY_BYTES), '0, 0);

        // remove first, relocated head, last, and a miss
        issue_command(CMD_REMOVE, str_text("ALPHA"), '0, 0);
        issue_command(CMD_REMOVE, str_text("abcdefghijklmnopqrstuvwxyz@[z"), '0, 0);
        issue_command(CMD_REMOVE, str_text(fill_names[4]), '0, 0);
        issue_command(CMD_REMOVE, str_text("nothere"), '0, 0);
        issue_command(CMD_LIST, '0, '0, 0);
        wait_drained();

        // random traffic in three sender idling phases
        for (int phase = 0; phase < 3; phase++) begin
            idle_pct = (phase == 0) ? 18 : (phase == 1) ? 48 : 0;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if ($urandom_range(0, 19) == 0)
                    name_pool[$urandom_range(0, POOL_SIZE - 1)] = fresh_text(KEY_BYTES);
                issue_command(pick_command(), pick_name(), pick_tag(), pick_amount(),
                              idle_pct);
            end
            wait_drained();
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (sb.pending() != 0)
            $error("%0d expected results never arrived", sb.pending());
        if (sb.mismatch_count == 0 && sb.pending() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule

@@ files.f @@
sv/ktci_pkg.sv
sv/ktci_dp.sv
sv/ktci_ctrl.sv
sv/keyed_table_case_insensitive_top.sv
bench/tb.sv
